>>> design/sliding_text_lane_scheduler_top_macros.svh
// Assertion macros for the sliding text lane scheduler.
// Included by the modules that check their own logic; needs no other file.
`ifndef SLIDING_TEXT_LANE_SCHEDULER_TOP_MACROS_SVH
`define SLIDING_TEXT_LANE_SCHEDULER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define STLSCH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lane scheduler check failed");
// next-cycle implication
`define STLSCH_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lane scheduler check failed");
`else
`define STLSCH_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define STLSCH_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> design/stlsch_pkg.sv
// Shared types and codes of the sliding text lane scheduler.
// No dependencies; used by every module of the block.
`default_nettype none

package stlsch_pkg;

   localparam int TW_W   = 12;  // text width
   localparam int SW_W   = 12;  // screen width
   localparam int POS_W  = 14;  // stored slot position, signed
   localparam int STEP_W = 13;  // per-frame step
   localparam int EXT_W  = 15;  // signed working width of the slot arithmetic

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_SPAN  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [SW_W-1:0] VIEW_WIDTH_RESET = 12'd1920;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_TICK,
      ST_TICK_END
   } state_type;

   typedef struct packed {
      logic            command;
      logic [TW_W-1:0] text_width;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        accepted;
      logic [2:0]  slot_row;
      logic [1:0]  slot_col;
      logic [11:0] dest_start;
      logic [10:0] source_start;
      logic [11:0] span_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [TW_W-1:0]   width;
      logic [STEP_W-1:0] step;
   } slot_rec_type;

   typedef struct packed {
      logic             overhang;
      logic             freed;
      logic [POS_W-1:0] new_pos;
   } alu_res_type;

   typedef struct packed {
      logic        visible;
      logic [11:0] dest;
      logic [10:0] src;
      logic [11:0] len;
   } span_type;

endpackage

`default_nettype wire

>>> design/stlsch_slot_mem.sv
// Slot record memory: one write port, one registered read port.
// Depends on stlsch_pkg for the record type.
`default_nettype none

module stlsch_slot_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                      clock,
   input  wire logic [AW-1:0]             rd_addr,
   output stlsch_pkg::slot_rec_type       rd_data,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire stlsch_pkg::slot_rec_type  wr_data
);

   stlsch_pkg::slot_rec_type slot_mem_ff [DEPTH];
   stlsch_pkg::slot_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/stlsch_slot_alu.sv
// Shared slot unit: overhang test for inserts, move and expiry for ticks.
// Depends on stlsch_pkg.
`default_nettype none

module stlsch_slot_alu (
   input  wire stlsch_pkg::slot_rec_type    rec,
   input  wire logic [stlsch_pkg::SW_W-1:0] view_width,
   output stlsch_pkg::alu_res_type          res
);

   logic signed [stlsch_pkg::EXT_W-1:0] pos_x;
   logic signed [stlsch_pkg::EXT_W-1:0] width_x;
   logic signed [stlsch_pkg::EXT_W-1:0] step_x;
   logic signed [stlsch_pkg::EXT_W-1:0] sw_x;
   logic signed [stlsch_pkg::EXT_W-1:0] right_x;
   logic signed [stlsch_pkg::EXT_W-1:0] moved_x;

   assign pos_x   = signed'({rec.pos[stlsch_pkg::POS_W-1], rec.pos});
   assign width_x = signed'({3'b000, rec.width});
   assign step_x  = signed'({2'b00, rec.step});
   assign sw_x    = signed'({3'b000, view_width});

   assign right_x = pos_x + width_x;
   assign moved_x = pos_x - step_x;

   always_comb begin
      res.overhang = right_x > sw_x;
      // free once the text has left the screen completely
      res.freed    = moved_x < -width_x;
      res.new_pos  = moved_x[stlsch_pkg::POS_W-1:0];
   end

endmodule

`default_nettype wire

>>> design/stlsch_span_clip.sv
// Clips one moved slot against the screen and forms its visible span.
// Depends on stlsch_pkg.
`default_nettype none

module stlsch_span_clip (
   input  wire logic [stlsch_pkg::POS_W-1:0] pos,
   input  wire logic [stlsch_pkg::TW_W-1:0]  width,
   input  wire logic [stlsch_pkg::SW_W-1:0]  view_width,
   output stlsch_pkg::span_type              span
);

   logic signed [stlsch_pkg::EXT_W-1:0] from_x;
   logic signed [stlsch_pkg::EXT_W-1:0] to_x;
   logic signed [stlsch_pkg::EXT_W-1:0] sw_x;
   logic signed [stlsch_pkg::EXT_W-1:0] from_c;
   logic signed [stlsch_pkg::EXT_W-1:0] to_c;
   logic signed [stlsch_pkg::EXT_W-1:0] src_x;
   logic signed [stlsch_pkg::EXT_W-1:0] len_x;

   assign from_x = signed'({pos[stlsch_pkg::POS_W-1], pos});
   assign sw_x   = signed'({3'b000, view_width});
   assign to_x   = from_x + signed'({3'b000, width}) - 15'sd1;

   always_comb begin
      from_c = (from_x < 15'sd0) ? 15'sd0 : from_x;
      src_x  = (from_x < 15'sd0) ? -from_x : 15'sd0;
      to_c   = (to_x >= sw_x) ? (sw_x - 15'sd1) : to_x;
      len_x  = to_c - from_c + 15'sd1;
      span.visible = (from_x < sw_x) && (to_x >= 15'sd0) && (width != '0);
      span.dest    = from_c[11:0];
      span.src     = src_x[10:0];
      span.len     = len_x[11:0];
   end

endmodule

`default_nettype wire

>>> design/stlsch_step_unit.sv
// Step computation: clamps the text width and divides by the pass length
// through a reciprocal multiply. Depends on stlsch_pkg.
`default_nettype none

module stlsch_step_unit #(
   parameter int CYCLES_PER_PASS = 256,
   parameter int MAX_TEXT_WIDTH  = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic [stlsch_pkg::TW_W-1:0]   text_width,
   input  wire logic [stlsch_pkg::SW_W-1:0]   view_width,
   output logic [stlsch_pkg::TW_W-1:0]        width_clamped,
   output logic [stlsch_pkg::STEP_W-1:0]      step
);

   localparam int X_W       = 13;
   localparam int RECIP_W   = 14;
   localparam int PROD_W    = X_W + RECIP_W;
   localparam int DIV_SHIFT = X_W + $clog2(CYCLES_PER_PASS);
   // exact floor division for every dividend below 2**X_W
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CYCLES_PER_PASS) - 64'd1)
               / 64'(CYCLES_PER_PASS));

   logic [stlsch_pkg::TW_W-1:0] wc_in;
   logic [stlsch_pkg::TW_W-1:0] width_ff;
   logic [X_W-1:0]              x_in;
   logic [X_W-1:0]              x_ff;
   logic [PROD_W-1:0]           prod_in;
   logic [PROD_W-1:0]           prod_ff;
   logic [X_W-1:0]              quot;

   assign wc_in = (13'(text_width) > 13'(MAX_TEXT_WIDTH)) ?
                  stlsch_pkg::TW_W'(MAX_TEXT_WIDTH) : text_width;
   assign x_in    = X_W'(wc_in) + X_W'(view_width);
   assign prod_in = PROD_W'(x_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         width_ff <= wc_in;
         x_ff     <= x_in;
      end
      prod_ff <= prod_in;
   end

   assign quot          = X_W'(prod_ff >> DIV_SHIFT);
   assign step          = quot + 13'd1;
   assign width_clamped = width_ff;

endmodule

`default_nettype wire

>>> design/sliding_text_lane_scheduler_top.sv
// Sliding text lane scheduler, top level: sequencer, slot pipeline, config.
// Depends on stlsch_pkg, stlsch_slot_mem, stlsch_slot_alu, stlsch_span_clip,
// stlsch_step_unit and the assertion macro header.
//
// One command at a time: busy is high from the cycle after start is taken
// and drops in the cycle that presents its last result. In a tick every slot
// passes once through the single memory read port and the shared slot unit,
// one slot per cycle. An insert finishes with the first row that can take
// the text; a tick emits its spans in row-major order followed by an end
// marker. Results appear on rsp_data for one cycle with rsp_valid and must
// be taken then; the block never waits for the receiver. Screen width
// changes take effect at once.
`default_nettype none
`include "sliding_text_lane_scheduler_top_macros.svh"

module sliding_text_lane_scheduler_top #(
   parameter int ROWS            = 8,
   parameter int COLS            = 4,
   parameter int CYCLES_PER_PASS = 256,
   parameter int MAX_TEXT_WIDTH  = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire stlsch_pkg::req_type           req_data,
   output logic                               rsp_valid,
   output stlsch_pkg::rsp_type                rsp_data,
   input  wire logic                          csr_write_en,
   input  wire logic [stlsch_pkg::SW_W-1:0]   csr_write_data
);

   localparam int SLOTS = ROWS * COLS;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   stlsch_pkg::state_type state_ff, state_in;
   logic [stlsch_pkg::SW_W-1:0] sw_ff;
   logic [SLOTS-1:0] active_ff, active_in;

   // issue side
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             done_ff, done_in;
   logic             issue;

   // read stage
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [ROW_W-1:0] rd_row_ff;
   logic [COL_W-1:0] rd_col_ff;
   logic             rd_act_ff;
   stlsch_pkg::slot_rec_type rd_rec;

   // per-row insert bookkeeping
   logic             row_ovh_ff, row_ovh_in;
   logic             row_free_ff, row_free_in;
   logic [IDX_W-1:0] row_fidx_ff, row_fidx_in;
   logic [COL_W-1:0] row_fcol_ff, row_fcol_in;

   // span stage
   logic                          b_vld_ff, b_vld_in;
   logic [stlsch_pkg::POS_W-1:0]  b_pos_ff;
   logic [stlsch_pkg::TW_W-1:0]   b_width_ff;
   logic [ROW_W-1:0]              b_row_ff;
   logic [COL_W-1:0]              b_col_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   stlsch_pkg::rsp_type rsp_ff, rsp_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   stlsch_pkg::slot_rec_type wr_rec;

   stlsch_pkg::alu_res_type     alu_res;
   stlsch_pkg::span_type        span;
   logic [stlsch_pkg::TW_W-1:0]   ins_width;
   logic [stlsch_pkg::STEP_W-1:0] ins_step;

   logic             accept;
   logic             ovh_c, free_seen, free_c, row_end, ins_grant, ins_refuse;
   logic [IDX_W-1:0] fidx;
   logic [COL_W-1:0] fcol;
   logic             tick_proc;

   assign busy   = (state_ff != stlsch_pkg::ST_IDLE);
   assign accept = start && !busy;

   stlsch_slot_mem #(.DEPTH(SLOTS), .AW(IDX_W)) u_mem (
      .clock   (clock),
      .rd_addr (addr_ff),
      .rd_data (rd_rec),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec)
   );

   stlsch_slot_alu u_alu (
      .rec        (rd_rec),
      .view_width (sw_ff),
      .res        (alu_res)
   );

   stlsch_span_clip u_clip (
      .pos        (b_pos_ff),
      .width      (b_width_ff),
      .view_width (sw_ff),
      .span       (span)
   );

   stlsch_step_unit #(
      .CYCLES_PER_PASS (CYCLES_PER_PASS),
      .MAX_TEXT_WIDTH  (MAX_TEXT_WIDTH)
   ) u_step (
      .clock         (clock),
      .load          (accept),
      .text_width    (req_data.text_width),
      .view_width    (sw_ff),
      .width_clamped (ins_width),
      .step          (ins_step)
   );

   // insert decision for the slot in the read stage
   assign row_end    = (rd_col_ff == LAST_COL);
   assign free_seen  = (rd_col_ff != '0) && row_free_ff;
   assign ovh_c      = ((rd_col_ff != '0) && row_ovh_ff) ||
                       (rd_act_ff && alu_res.overhang);
   assign free_c     = free_seen || !rd_act_ff;
   assign fidx       = free_seen ? row_fidx_ff : rd_idx_ff;
   assign fcol       = free_seen ? row_fcol_ff : rd_col_ff;
   assign ins_grant  = (state_ff == stlsch_pkg::ST_INSERT) && rd_vld_ff &&
                       row_end && !ovh_c && free_c;
   assign ins_refuse = (state_ff == stlsch_pkg::ST_INSERT) && rd_vld_ff &&
                       (rd_idx_ff == LAST_IDX) && !ins_grant;
   assign tick_proc  = ((state_ff == stlsch_pkg::ST_TICK) ||
                        (state_ff == stlsch_pkg::ST_TICK_END)) &&
                       rd_vld_ff && rd_act_ff;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      addr_in      = addr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      done_in      = done_ff;
      issue        = 1'b0;
      rd_vld_in    = 1'b0;
      row_ovh_in   = row_ovh_ff;
      row_free_in  = row_free_ff;
      row_fidx_in  = row_fidx_ff;
      row_fcol_in  = row_fcol_ff;
      b_vld_in     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_rec       = rd_rec;

      unique case (state_ff)
         stlsch_pkg::ST_IDLE: begin
            if (start) begin
               addr_in  = '0;
               row_in   = '0;
               col_in   = '0;
               done_in  = 1'b0;
               state_in = (req_data.command == stlsch_pkg::CMD_INSERT) ?
                          stlsch_pkg::ST_INSERT : stlsch_pkg::ST_TICK;
            end
         end
         stlsch_pkg::ST_INSERT: begin
            issue = !done_ff && !ins_grant && !ins_refuse;
            if (rd_vld_ff) begin
               row_ovh_in  = ovh_c;
               row_free_in = free_c;
               row_fidx_in = fidx;
               row_fcol_in = fcol;
            end
            if (ins_grant) begin
               active_in[fidx] = 1'b1;
               wr_en        = 1'b1;
               wr_addr      = fidx;
               wr_rec.pos   = stlsch_pkg::POS_W'(sw_ff);
               wr_rec.width = ins_width;
               wr_rec.step  = ins_step;
               rsp_valid_in = 1'b1;
               rsp_in.kind     = stlsch_pkg::KIND_REPLY;
               rsp_in.accepted = 1'b1;
               rsp_in.slot_row = 3'(rd_row_ff);
               rsp_in.slot_col = 2'(fcol);
               rsp_in.last     = 1'b1;
               state_in     = stlsch_pkg::ST_IDLE;
            end else if (ins_refuse) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = stlsch_pkg::KIND_REPLY;
               rsp_in.last  = 1'b1;
               state_in     = stlsch_pkg::ST_IDLE;
            end
         end
         stlsch_pkg::ST_TICK: begin
            issue = 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = stlsch_pkg::ST_TICK_END;
            end
         end
         stlsch_pkg::ST_TICK_END: begin
            // hold the end marker until the last span has gone out
            if (!rd_vld_ff && !b_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = stlsch_pkg::KIND_END;
               rsp_in.last  = 1'b1;
               state_in     = stlsch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stlsch_pkg::ST_IDLE;
         end
      endcase

      // move the slot, write it back, drop it once off screen
      if (tick_proc) begin
         active_in[rd_idx_ff] = !alu_res.freed;
         wr_en      = !alu_res.freed;
         wr_rec.pos = alu_res.new_pos;
         b_vld_in   = !alu_res.freed;
      end

      if (b_vld_ff && span.visible) begin
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = stlsch_pkg::KIND_SPAN;
         rsp_in.slot_row     = 3'(b_row_ff);
         rsp_in.slot_col     = 2'(b_col_ff);
         rsp_in.dest_start   = span.dest;
         rsp_in.source_start = span.src;
         rsp_in.span_length  = span.len;
      end

      // advance the row-major slot walk
      if (issue) begin
         rd_vld_in = 1'b1;
         addr_in   = addr_ff + 1'b1;
         if (addr_ff == LAST_IDX) begin
            done_in = 1'b1;
         end
         if (col_ff == LAST_COL) begin
            col_in = '0;
            row_in = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stlsch_pkg::ST_IDLE;
         sw_ff        <= stlsch_pkg::VIEW_WIDTH_RESET;
         active_ff    <= '0;
         done_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         done_ff      <= done_in;
         rd_vld_ff    <= rd_vld_in;
         b_vld_ff     <= b_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            sw_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      rd_idx_ff   <= addr_ff;
      rd_row_ff   <= row_ff;
      rd_col_ff   <= col_ff;
      rd_act_ff   <= active_ff[addr_ff];
      row_ovh_ff  <= row_ovh_in;
      row_free_ff <= row_free_in;
      row_fidx_ff <= row_fidx_in;
      row_fcol_ff <= row_fcol_in;
      b_pos_ff    <= alu_res.new_pos;
      b_width_ff  <= rd_rec.width;
      b_row_ff    <= rd_row_ff;
      b_col_ff    <= rd_col_ff;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `STLSCH_ASSERT_NXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `STLSCH_ASSERT_IMP(a_last_frees_block, clock, reset,
      rsp_valid && rsp_data.last, !busy)
   `STLSCH_ASSERT_IMP(a_span_not_last, clock, reset,
      rsp_valid && rsp_data.kind == stlsch_pkg::KIND_SPAN, !rsp_data.last)
   `STLSCH_ASSERT_IMP(a_span_stage_in_tick, clock, reset, b_vld_ff,
      state_ff == stlsch_pkg::ST_TICK || state_ff == stlsch_pkg::ST_TICK_END)
   `STLSCH_ASSERT_NXT(a_grant_replies, clock, reset, ins_grant,
      rsp_valid && rsp_data.accepted)

endmodule

`default_nettype wire

>>> tb/sv/sliding_text_lane_scheduler_top_test.sv
// Self-checking bench for sliding_text_lane_scheduler_top: scoreboard class plus driver.
// Depends on stlsch_pkg and the scheduler RTL; needs no other file.

class lane_grid_tracker;
   localparam int GRID_ROWS      = 8;
   localparam int GRID_COLS      = 4;
   localparam int GRID_SLOTS     = GRID_ROWS * GRID_COLS;
   localparam int PASS_FRAMES    = 256;
   localparam int TEXT_WIDTH_MAX = 2048;
   localparam int PRINT_CAP      = 40;

   logic [stlsch_pkg::SW_W-1:0]         view_width;
   bit                                  lane_active [GRID_SLOTS];
   logic signed [stlsch_pkg::POS_W-1:0] lane_pos    [GRID_SLOTS];
   logic [stlsch_pkg::TW_W-1:0]         lane_width  [GRID_SLOTS];
   logic [stlsch_pkg::STEP_W-1:0]       lane_step   [GRID_SLOTS];
   stlsch_pkg::rsp_type                 results_due [$];
   int                                  error_count;
   int                                  checked;

   function new();
      view_width  = stlsch_pkg::VIEW_WIDTH_RESET;
      error_count = 0;
      checked     = 0;
      for (int i = 0; i < GRID_SLOTS; i++) begin
         lane_active[i] = 1'b0;
         lane_pos[i]    = '0;
         lane_width[i]  = '0;
         lane_step[i]   = '0;
      end
   endfunction

   function bit pending();
      return results_due.size() != 0;
   endfunction

   function bit any_active();
      for (int i = 0; i < GRID_SLOTS; i++)
         if (lane_active[i])
            return 1'b1;
      return 1'b0;
   endfunction

   // a row blocks entry while another of its texts still crosses the right edge
   function bit row_overhangs(int row, int skip_col, int sw);
      int idx;
      for (int col = 0; col < GRID_COLS; col++) begin
         idx = row * GRID_COLS + col;
         if (col != skip_col && lane_active[idx] &&
             int'(lane_pos[idx]) + int'(lane_width[idx]) > sw)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // note one accepted transfer and queue the results it must produce
   function void take_command(stlsch_pkg::req_type item);
      int                  sw, w, idx, row, col, pos, from, to, src;
      bit                  granted;
      stlsch_pkg::rsp_type r;
      sw = int'(view_width);
      if (item.command == stlsch_pkg::CMD_INSERT) begin
         w = int'(item.text_width);
         if (w > TEXT_WIDTH_MAX)
            w = TEXT_WIDTH_MAX;
         r = '0;
         r.kind = stlsch_pkg::KIND_REPLY;
         r.last = 1'b1;
         granted = 1'b0;
         for (row = 0; row < GRID_ROWS && !granted; row++) begin
            for (col = 0; col < GRID_COLS && !granted; col++) begin
               idx = row * GRID_COLS + col;
               if (!lane_active[idx] && !row_overhangs(row, col, sw)) begin
                  lane_active[idx] = 1'b1;
                  lane_pos[idx]    = stlsch_pkg::POS_W'(sw);
                  lane_width[idx]  = stlsch_pkg::TW_W'(w);
                  lane_step[idx]   = stlsch_pkg::STEP_W'(1 + (w + sw) / PASS_FRAMES);
                  r.accepted = 1'b1;
                  r.slot_row = row[2:0];
                  r.slot_col = col[1:0];
                  granted    = 1'b1;
               end
            end
         end
         results_due.push_back(r);
         return;
      end

      // advance every text, drop the ones fully past the left edge
      for (idx = 0; idx < GRID_SLOTS; idx++) begin
         if (lane_active[idx]) begin
            pos = int'(lane_pos[idx]) - int'(lane_step[idx]);
            lane_pos[idx] = stlsch_pkg::POS_W'(pos);
            if (pos < -int'(lane_width[idx]))
               lane_active[idx] = 1'b0;
         end
      end

      for (row = 0; row < GRID_ROWS; row++) begin
         for (col = 0; col < GRID_COLS; col++) begin
            idx = row * GRID_COLS + col;
            if (!lane_active[idx])
               continue;
            from = int'(lane_pos[idx]);
            to   = from + int'(lane_width[idx]) - 1;
            src  = 0;
            if (from >= sw || to < 0 || to < from)
               continue;
            if (from < 0) begin
               src  = -from;
               from = 0;
            end
            if (to >= sw)
               to = sw - 1;
            r = '0;
            r.kind         = stlsch_pkg::KIND_SPAN;
            r.slot_row     = row[2:0];
            r.slot_col     = col[1:0];
            r.dest_start   = from[11:0];
            r.source_start = src[10:0];
            r.span_length  = 12'(to - from + 1);
            results_due.push_back(r);
         end
      end
      r = '0;
      r.kind = stlsch_pkg::KIND_END;
      r.last = 1'b1;
      results_due.push_back(r);
   endfunction

   task report_mismatch(string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t: mismatch on result %0d: %s", $time, checked, msg);
   endtask

   task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
   endtask

   task check_result(stlsch_pkg::rsp_type got);
      stlsch_pkg::rsp_type want;
      if (results_due.size() == 0) begin
         report_mismatch("result with no command outstanding");
         return;
      end
      want = results_due.pop_front();
      compare_field("kind", 16'(got.kind), 16'(want.kind));
      compare_field("accepted", 16'(got.accepted), 16'(want.accepted));
      compare_field("slot_row", 16'(got.slot_row), 16'(want.slot_row));
      compare_field("slot_col", 16'(got.slot_col), 16'(want.slot_col));
      compare_field("dest_start", 16'(got.dest_start), 16'(want.dest_start));
      compare_field("source_start", 16'(got.source_start), 16'(want.source_start));
      compare_field("span_length", 16'(got.span_length), 16'(want.span_length));
      compare_field("last", 16'(got.last), 16'(want.last));
      checked++;
   endtask
endclass

module sliding_text_lane_scheduler_top_test;
   localparam int CYCLE_LIMIT = 400000;

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        start          = 1'b0;
   stlsch_pkg::req_type         req_data       = '0;
   logic                        csr_write_en   = 1'b0;
   logic [stlsch_pkg::SW_W-1:0] csr_write_data = '0;
   logic                        busy;
   logic                        rsp_valid;
   stlsch_pkg::rsp_type         rsp_data;

   lane_grid_tracker lanes = new();
   int               idle_pct    = 0;
   int               cycle_count = 0;

   sliding_text_lane_scheduler_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // results cannot be held off: take every strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         lanes.check_result(rsp_data);
   end

   // hold start until the transfer; lower it only when a gap follows
   task automatic send_cmd(input logic cmd, input logic [stlsch_pkg::TW_W-1:0] width);
      stlsch_pkg::req_type item;
      item.command    = cmd;
      item.text_width = width;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      lanes.take_command(item);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 45)) @(posedge clock);
      end
   endtask

   task automatic write_view_width(input logic [stlsch_pkg::SW_W-1:0] value);
      start <= 1'b0;
      while (lanes.pending() || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      lanes.view_width = value;
   endtask

   task automatic run_random(input int count, input int idle);
      logic [stlsch_pkg::TW_W-1:0] width;
      idle_pct = idle;
      repeat (count) begin
         if ($urandom_range(0, 99) < 70) begin
            width = stlsch_pkg::TW_W'($urandom);
            send_cmd(stlsch_pkg::CMD_TICK, width);
         end else begin
            case ($urandom_range(0, 9))
               0: width = '0;
               1: width = stlsch_pkg::TW_W'($urandom_range(2049, 4095));
               2: width = stlsch_pkg::TW_W'($urandom);
               default: width = stlsch_pkg::TW_W'($urandom_range(1, 300));
            endcase
            send_cmd(stlsch_pkg::CMD_INSERT, width);
         end
      end
   endtask

   initial begin
      int guard;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      send_cmd(stlsch_pkg::CMD_TICK, '0);
      send_cmd(stlsch_pkg::CMD_INSERT, '0);
      send_cmd(stlsch_pkg::CMD_INSERT, 12'hFFF);
      send_cmd(stlsch_pkg::CMD_INSERT, 12'd2048);
      send_cmd(stlsch_pkg::CMD_INSERT, 12'd1);
      send_cmd(stlsch_pkg::CMD_TICK, 12'hFFF);
      send_cmd(stlsch_pkg::CMD_TICK, '0);

      // narrow the screen with texts still far right of the new edge
      write_view_width(12'd100);
      send_cmd(stlsch_pkg::CMD_TICK, '0);
      repeat (5) send_cmd(stlsch_pkg::CMD_INSERT, 12'd1);
      send_cmd(stlsch_pkg::CMD_INSERT, 12'd40);
      send_cmd(stlsch_pkg::CMD_TICK, 12'h555);
      send_cmd(stlsch_pkg::CMD_TICK, 12'hAAA);

      run_random(60, 76);

      // tick a while so that rows free up before texts enter a zero-width screen
      idle_pct = 34;
      guard = 0;
      while (lanes.any_active() && guard < 30) begin
         send_cmd(stlsch_pkg::CMD_TICK, '0);
         guard++;
      end

      write_view_width('0);
      run_random(30, 0);
      write_view_width(stlsch_pkg::SW_W'($urandom_range(100, 4095)));
      run_random(40, 34);
      write_view_width(12'd4095);
      run_random(30, 76);
      write_view_width(stlsch_pkg::SW_W'($urandom_range(1, 400)));
      run_random(40, 0);

      start <= 1'b0;
      while (lanes.pending())
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (lanes.error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
